FILE: rtl/srfd_pkg.sv
// Package for the steering return force drive: transaction payload types,
// configuration register types, request and drive mode codes, drive table.
// No dependencies.
package srfd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Request codes.
	localparam logic [2:0] REQ_TICK     = 3'd0;
	localparam logic [2:0] REQ_ENABLE   = 3'd1;
	localparam logic [2:0] REQ_DISABLE  = 3'd2;
	localparam logic [2:0] REQ_INCREASE = 3'd3;
	localparam logic [2:0] REQ_DECREASE = 3'd4;

	// Drive modes.
	localparam logic [1:0] MODE_FWD   = 2'd0;
	localparam logic [1:0] MODE_REV   = 2'd1;
	localparam logic [1:0] MODE_BRAKE = 2'd2;
	localparam logic [1:0] MODE_FREE  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_CENTER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_CCW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_CW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPRING_GAIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STRENGTH = 3'd7;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] steer_position;
	} req_t;

	typedef struct packed {
		logic [15:0] pulse_width;
		logic        pwm_enable;
		logic        bridge_in1;
		logic        bridge_in2;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        encoder_center;
		logic signed [15:0] deadband_ccw;
		logic [14:0]        deadband_cw;
		logic [15:0]        spring_gain;
		logic [15:0]        min_duty;
		logic [15:0]        max_duty;
		logic [15:0]        pwm_period;
		logic [15:0]        default_strength;
	} cfg_t;

	// Drive table: {enable, in1, in2} for each mode.
	function automatic logic [2:0] drive_bits(input logic [1:0] mode);
		logic [2:0] bits;
		case (mode)
			MODE_FWD:   bits = 3'b110;
			MODE_REV:   bits = 3'b101;
			MODE_BRAKE: bits = 3'b111;
			default:    bits = 3'b000;
		endcase
		return bits;
	endfunction

endpackage

FILE: rtl/srfd_cfg.sv
// Configuration register file of the steering return force drive.
// Depends on srfd_pkg.
module srfd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output srfd_pkg::cfg_t                  cfg
);
	import srfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.encoder_center   <= 16'd32768;
			cfg_q.deadband_ccw     <= -16'sd16;
			cfg_q.deadband_cw      <= 15'd16;
			cfg_q.spring_gain      <= 16'd786;
			cfg_q.min_duty         <= 16'd0;
			cfg_q.max_duty         <= 16'd16384;
			cfg_q.pwm_period       <= 16'd1000;
			cfg_q.default_strength <= 16'd6554;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ENCODER_CENTER:   cfg_q.encoder_center   <= cfg_wdata;
				CFG_DEADBAND_CCW:     cfg_q.deadband_ccw     <= $signed(cfg_wdata);
				CFG_DEADBAND_CW:      cfg_q.deadband_cw      <= cfg_wdata[14:0];
				CFG_SPRING_GAIN:      cfg_q.spring_gain      <= cfg_wdata;
				CFG_MIN_DUTY:         cfg_q.min_duty         <= cfg_wdata;
				CFG_MAX_DUTY:         cfg_q.max_duty         <= cfg_wdata;
				CFG_PWM_PERIOD:       cfg_q.pwm_period       <= cfg_wdata;
				CFG_DEFAULT_STRENGTH: cfg_q.default_strength <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/srfd_mul.sv
// Shared 16 x 16 unsigned multiplier with a registered product.
// No package dependencies.
module srfd_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] op_a,
	input  logic [15:0] op_b,
	output logic [31:0] prod
);

	logic [31:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

	assign prod = prod_q;

endmodule

FILE: rtl/steering_return_force_drive_core.sv
// Top level of the steering return force drive: request sequencer, held
// state, duty clamp and output register. Depends on srfd_pkg, srfd_cfg
// and srfd_mul.

// Each request transaction produces exactly one result transaction with the
// pulse width and the H-bridge drive lines. Work is done one transaction at
// a time by a small sequencer around a single shared 16 x 16 multiplier:
// a tick outside the deadband uses it twice (spring gain times offset, then
// duty times PWM period) via MAG, CLAMP, SCALE and OUT; enable, disable,
// increase, decrease and a tick inside the deadband use it once via CLAMP,
// SCALE and OUT, and an ignored tick or an unknown request code goes
// straight to OUT. The result sits in an output register, so a new request
// can be accepted while the previous result waits; a stalled output holds
// the sequencer in OUT only when the next result is ready to leave. Duties,
// strengths and gain are fractions with FRAC_BITS fraction bits, and the
// pulse width is floor(duty * period / 2^FRAC_BITS), saturated to 16 bits.
// Configuration writes are to be done while the block is idle.
module steering_return_force_drive_core #(
	parameter int STRENGTH_STEP = 655,
	parameter int FRAC_BITS     = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  srfd_pkg::req_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output srfd_pkg::rsp_t                  out_data
);
	import srfd_pkg::*;

	localparam logic [17:0] STEP     = 18'(STRENGTH_STEP);
	localparam logic [17:0] HELD_MAX = 18'h3FFFF;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MAG   = 5'b00010,
		ST_CLAMP = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	cfg_t cfg;

	state_t      state_q;
	logic        active_q;
	logic [1:0]  mode_q;
	logic [17:0] held_q;
	logic [15:0] pulse_q;
	logic [31:0] str_q;
	logic [15:0] abs_off_q;
	logic        neg_q;
	logic        from_mul_q;
	logic        upd_q;
	logic [15:0] duty_q;
	logic        out_valid_q;
	rsp_t        out_q;

	logic        accept;
	logic        mul_en;
	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] prod;

	logic signed [15:0] off;
	logic signed [15:0] hi_edge;
	logic               in_band;
	logic [18:0]        held_sum;
	logic [17:0]        held_inc;
	logic [17:0]        held_dec;
	logic [31:0]        clamp_in;
	logic [15:0]        duty_nxt;
	logic [31:0]        scaled;
	logic [15:0]        pulse_nxt;
	logic               out_load;

	srfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The multiplier serves the force product in MAG and the pulse width
	// product in SCALE; its product is valid in the following state.
	assign mul_en = (state_q == ST_MAG) || (state_q == ST_SCALE);
	assign mul_a  = (state_q == ST_MAG) ? cfg.spring_gain : duty_q;
	assign mul_b  = (state_q == ST_MAG) ? abs_off_q : cfg.pwm_period;

	srfd_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Wheel offset from centre wraps in 16 bits; the deadband is inclusive.
	assign off     = $signed(in_data.steer_position - cfg.encoder_center);
	assign hi_edge = $signed({1'b0, cfg.deadband_cw});
	assign in_band = (off >= cfg.deadband_ccw) && (off <= hi_edge);

	// Held strength saturates at both ends.
	assign held_sum = {1'b0, held_q} + {1'b0, STEP};
	assign held_inc = held_sum[18] ? HELD_MAX : held_sum[17:0];
	assign held_dec = (held_q > STEP) ? (held_q - STEP) : 18'd0;

	// Clamp: below min gives min, above max gives max. When min is above
	// max, anything not below min therefore lands on max.
	assign clamp_in = from_mul_q ? prod : str_q;
	always_comb begin
		if (clamp_in < {16'd0, cfg.min_duty}) begin
			duty_nxt = cfg.min_duty;
		end else if (clamp_in > {16'd0, cfg.max_duty}) begin
			duty_nxt = cfg.max_duty;
		end else begin
			duty_nxt = clamp_in[15:0];
		end
	end

	assign scaled    = prod >> FRAC_BITS;
	assign pulse_nxt = !upd_q ? pulse_q :
		((scaled[31:16] != 16'd0) ? 16'hFFFF : scaled[15:0]);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b1;
			mode_q   <= MODE_FREE;
			held_q   <= 18'd0;
			pulse_q  <= 16'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.req_type)
							REQ_TICK: begin
								if (!active_q) begin
									state_q <= ST_OUT;
								end else if (in_band) begin
									mode_q  <= MODE_FREE;
									state_q <= ST_CLAMP;
								end else begin
									state_q <= ST_MAG;
								end
							end
							REQ_ENABLE: begin
								active_q <= 1'b1;
								state_q  <= ST_CLAMP;
							end
							REQ_DISABLE: begin
								active_q <= 1'b0;
								state_q  <= ST_CLAMP;
							end
							REQ_INCREASE: begin
								held_q  <= held_inc;
								state_q <= ST_CLAMP;
							end
							REQ_DECREASE: begin
								held_q  <= held_dec;
								state_q <= ST_CLAMP;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_MAG: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					// A tick outside the deadband picks its drive direction here,
					// once the force magnitude is known.
					if (from_mul_q) begin
						if (prod == 32'd0) begin
							mode_q <= MODE_FREE;
						end else if (neg_q) begin
							mode_q <= MODE_FWD;
						end else begin
							mode_q <= MODE_REV;
						end
					end
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						pulse_q <= pulse_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			abs_off_q  <= off[15] ? (cfg.encoder_center - in_data.steer_position)
				: $unsigned(off);
			neg_q      <= off[15];
			from_mul_q <= (in_data.req_type == REQ_TICK) && !in_band;
			case (in_data.req_type)
				REQ_TICK: begin
					str_q <= 32'd0;
					upd_q <= active_q;
				end
				REQ_ENABLE: begin
					str_q <= (held_q == 18'd0) ? {16'd0, cfg.default_strength}
						: {14'd0, held_q};
					upd_q <= 1'b1;
				end
				REQ_DISABLE: begin
					str_q <= 32'd0;
					upd_q <= 1'b1;
				end
				REQ_INCREASE: begin
					str_q <= {14'd0, held_inc};
					upd_q <= 1'b1;
				end
				REQ_DECREASE: begin
					str_q <= {14'd0, held_dec};
					upd_q <= 1'b1;
				end
				default: begin
					str_q <= 32'd0;
					upd_q <= 1'b0;
				end
			endcase
		end
		if (state_q == ST_CLAMP) begin
			duty_q <= duty_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.pulse_width <= pulse_nxt;
			{out_q.pwm_enable, out_q.bridge_in1, out_q.bridge_in2} <= drive_bits(mode_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("block ready again right after accepting a transaction");

	a_mag_then_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAG) |=> (state_q == ST_CLAMP))
		else $error("force product not followed by clamp");

	a_free_lines_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.pwm_enable) |-> (!out_data.bridge_in1 && !out_data.bridge_in2))
		else $error("bridge lines driven while PWM is off");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid)
		else $error("result loaded but not presented");
`endif

endmodule
